FILE: rtl/trpi_pkg.sv
// Package for the turn rate PI controller: field widths, register indexes,
// register reset values and the structs shared by the controller modules.
// Depends on nothing.
package trpi_pkg;

  localparam int GYRO_W     = 16;
  localparam int RATE_W     = 13;
  localparam int DRIVE_W    = 16;
  localparam int TGT_W      = 9;
  localparam int ERR_W      = 14;
  localparam int INTEG_W    = 16;
  localparam int GAIN_W     = 8;
  localparam int LIMIT_W    = 15;
  localparam int SHIFT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAG_W      = 24;
  localparam int NUM_STAGES = 6;

  localparam int TARGET_MAX = 180;
  localparam int RATE_MAX   = 4095;
  localparam int RATE_NEG_MAX = 4096;
  localparam int RATE_FRAC_W  = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_RATE  = 3'd0,
    CFG_PROP_GAIN    = 3'd1,
    CFG_INTEG_GAIN   = 3'd2,
    CFG_INTEG_LIMIT  = 3'd3,
    CFG_SMOOTH_SHIFT = 3'd4,
    CFG_MAX_DRIVE    = 3'd5,
    CFG_ZERO_OFFSET  = 3'd6,
    CFG_INVERT_DRIVE = 3'd7
  } cfg_idx_e;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 8'd35;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 8'd1;
  localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST  = 15'd3000;
  localparam logic [SHIFT_W-1:0] SMOOTH_SHIFT_RST = 3'd2;
  localparam logic [LIMIT_W-1:0] MAX_DRIVE_RST    = 15'd30;

  typedef struct packed {
    logic signed [TGT_W-1:0]  target_rate;
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        integ_gain;
    logic [LIMIT_W-1:0]       integ_limit;
    logic [SHIFT_W-1:0]       smooth_shift;
    logic [LIMIT_W-1:0]       max_drive;
    logic signed [GYRO_W-1:0] zero_offset;
    logic                     invert_drive;
  } cfg_t;

  typedef struct packed {
    logic in_reg;
    logic conv;
    logic loop;
    logic mult;
    logic recip;
    logic result;
  } pipe_ld_t;

endpackage

FILE: rtl/trpi_cfg_regs.sv
// Configuration registers of the turn rate PI controller.
// Target rate is saturated on write. Depends on trpi_pkg.
module trpi_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [trpi_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [trpi_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output trpi_pkg::cfg_t                     cfg_o
);

  trpi_pkg::cfg_t                        cfg_q;
  logic signed [trpi_pkg::TGT_W-1:0]     tgt_raw;
  logic signed [trpi_pkg::TGT_W-1:0]     tgt_sat;

  assign tgt_raw = $signed(cfg_data_i[trpi_pkg::TGT_W-1:0]);

  always_comb begin
    if (tgt_raw > $signed(9'(trpi_pkg::TARGET_MAX))) begin
      tgt_sat = 9'(trpi_pkg::TARGET_MAX);
    end else if (tgt_raw < -$signed(9'(trpi_pkg::TARGET_MAX))) begin
      tgt_sat = -$signed(9'(trpi_pkg::TARGET_MAX));
    end else begin
      tgt_sat = tgt_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_rate  <= '0;
      cfg_q.prop_gain    <= trpi_pkg::PROP_GAIN_RST;
      cfg_q.integ_gain   <= trpi_pkg::INTEG_GAIN_RST;
      cfg_q.integ_limit  <= trpi_pkg::INTEG_LIMIT_RST;
      cfg_q.smooth_shift <= trpi_pkg::SMOOTH_SHIFT_RST;
      cfg_q.max_drive    <= trpi_pkg::MAX_DRIVE_RST;
      cfg_q.zero_offset  <= '0;
      cfg_q.invert_drive <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (trpi_pkg::cfg_idx_e'(cfg_idx_i))
        trpi_pkg::CFG_TARGET_RATE:  cfg_q.target_rate  <= tgt_sat;
        trpi_pkg::CFG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_data_i[trpi_pkg::GAIN_W-1:0];
        trpi_pkg::CFG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_data_i[trpi_pkg::GAIN_W-1:0];
        trpi_pkg::CFG_INTEG_LIMIT:  cfg_q.integ_limit  <= cfg_data_i[trpi_pkg::LIMIT_W-1:0];
        trpi_pkg::CFG_SMOOTH_SHIFT: cfg_q.smooth_shift <= cfg_data_i[trpi_pkg::SHIFT_W-1:0];
        trpi_pkg::CFG_MAX_DRIVE:    cfg_q.max_drive    <= cfg_data_i[trpi_pkg::LIMIT_W-1:0];
        trpi_pkg::CFG_ZERO_OFFSET:  cfg_q.zero_offset  <= $signed(cfg_data_i);
        trpi_pkg::CFG_INVERT_DRIVE: cfg_q.invert_drive <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/trpi_rate_conv.sv
// Input register and raw-to-degrees-per-second conversion stage.
// Removes the zero offset, scales by full scale over 32768 and saturates.
// Depends on trpi_pkg.
module trpi_rate_conv #(
  parameter int FULL_SCALE_DPS = 2000
) (
  input  logic                                 clk_i,
  input  trpi_pkg::cfg_t                       cfg_i,
  input  trpi_pkg::pipe_ld_t                   ld_i,
  input  logic                                 mode_i,
  input  logic signed [trpi_pkg::GYRO_W-1:0]   gyro_raw_i,
  output logic                                 mode_o,
  output logic signed [trpi_pkg::RATE_W-1:0]   rate_o
);

  localparam int DIFF_W = trpi_pkg::GYRO_W + 1;
  localparam int PROD_W = DIFF_W + $clog2(FULL_SCALE_DPS + 1) + 1;
  localparam int RND_W  = PROD_W - trpi_pkg::RATE_FRAC_W;
  localparam int EXT_W  = (RND_W > trpi_pkg::RATE_W + 1) ? RND_W : trpi_pkg::RATE_W + 1;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (trpi_pkg::RATE_FRAC_W - 1);

  logic                                mode0_q;
  logic signed [trpi_pkg::GYRO_W-1:0]  gyro0_q;
  logic                                mode1_q;
  logic signed [trpi_pkg::RATE_W-1:0]  rate1_q;

  logic signed [DIFF_W-1:0]            diff;
  logic [DIFF_W-1:0]                   diff_mag;
  logic [PROD_W-1:0]                   prod;
  logic [PROD_W-1:0]                   prod_rnd;
  logic [EXT_W-1:0]                    rnd_ext;
  logic signed [trpi_pkg::RATE_W-1:0]  rate_d;

  assign diff     = {gyro0_q[trpi_pkg::GYRO_W-1], gyro0_q}
                  - {cfg_i.zero_offset[trpi_pkg::GYRO_W-1], cfg_i.zero_offset};
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign prod     = PROD_W'(diff_mag) * PROD_W'(FULL_SCALE_DPS);
  assign prod_rnd = prod + ROUND_HALF;
  assign rnd_ext  = EXT_W'(prod_rnd[PROD_W-1:trpi_pkg::RATE_FRAC_W]);

  always_comb begin
    if (!diff[DIFF_W-1]) begin
      if (rnd_ext > EXT_W'(trpi_pkg::RATE_MAX)) begin
        rate_d = trpi_pkg::RATE_W'(trpi_pkg::RATE_MAX);
      end else begin
        rate_d = trpi_pkg::RATE_W'(rnd_ext);
      end
    end else begin
      if (rnd_ext > EXT_W'(trpi_pkg::RATE_NEG_MAX)) begin
        rate_d = trpi_pkg::RATE_W'(-EXT_W'(trpi_pkg::RATE_NEG_MAX));
      end else begin
        rate_d = trpi_pkg::RATE_W'(-rnd_ext);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.in_reg) begin
      mode0_q <= mode_i;
      gyro0_q <= gyro_raw_i;
    end
    if (ld_i.conv) begin
      mode1_q <= mode0_q;
      rate1_q <= rate_d;
    end
  end

  assign mode_o = mode1_q;
  assign rate_o = rate1_q;

endmodule

FILE: rtl/trpi_loop_update.sv
// Rate filter and integral accumulator update, the only feedback loop.
// Produces the error, new integral and filtered rate. Depends on trpi_pkg.
module trpi_loop_update (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  trpi_pkg::cfg_t                       cfg_i,
  input  trpi_pkg::pipe_ld_t                   ld_i,
  input  logic                                 mode_i,
  input  logic signed [trpi_pkg::RATE_W-1:0]   rate_i,
  output logic signed [trpi_pkg::ERR_W-1:0]    err_o,
  output logic signed [trpi_pkg::INTEG_W-1:0]  integ_o,
  output logic signed [trpi_pkg::RATE_W-1:0]   filt_o
);

  localparam int SUM_W = trpi_pkg::INTEG_W + 1;

  logic signed [trpi_pkg::RATE_W-1:0]   filt_q;
  logic signed [trpi_pkg::INTEG_W-1:0]  integ_q;
  logic signed [trpi_pkg::ERR_W-1:0]    err2_q;
  logic signed [trpi_pkg::INTEG_W-1:0]  integ2_q;
  logic signed [trpi_pkg::RATE_W-1:0]   filt2_q;

  logic signed [trpi_pkg::RATE_W:0]     fdiff;
  logic signed [trpi_pkg::RATE_W:0]     fstep;
  logic signed [trpi_pkg::RATE_W:0]     fsum;
  logic signed [trpi_pkg::RATE_W-1:0]   filt_d;
  logic signed [trpi_pkg::ERR_W-1:0]    err_d;
  logic signed [SUM_W-1:0]              isum;
  logic signed [SUM_W-1:0]              ilim;
  logic signed [trpi_pkg::INTEG_W-1:0]  integ_d;

  assign fdiff = {rate_i[trpi_pkg::RATE_W-1], rate_i} - {filt_q[trpi_pkg::RATE_W-1], filt_q};
  assign fstep = fdiff >>> cfg_i.smooth_shift;
  assign fsum  = {filt_q[trpi_pkg::RATE_W-1], filt_q} + fstep;
  assign ilim  = $signed({2'b00, cfg_i.integ_limit});

  always_comb begin
    filt_d  = trpi_pkg::RATE_W'(fsum);
    err_d   = {{(trpi_pkg::ERR_W - trpi_pkg::TGT_W){cfg_i.target_rate[trpi_pkg::TGT_W-1]}},
               cfg_i.target_rate}
            - {filt_d[trpi_pkg::RATE_W-1], filt_d};
    isum    = {integ_q[trpi_pkg::INTEG_W-1], integ_q}
            + {{(SUM_W - trpi_pkg::ERR_W){err_d[trpi_pkg::ERR_W-1]}}, err_d};
    if (cfg_i.integ_gain == '0) begin
      integ_d = '0;
    end else if (isum > ilim) begin
      integ_d = trpi_pkg::INTEG_W'(ilim);
    end else if (isum < -ilim) begin
      integ_d = trpi_pkg::INTEG_W'(-ilim);
    end else begin
      integ_d = trpi_pkg::INTEG_W'(isum);
    end
    if (mode_i) begin
      filt_d  = '0;
      err_d   = '0;
      integ_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q  <= '0;
      integ_q <= '0;
    end else if (ld_i.loop) begin
      filt_q  <= filt_d;
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.loop) begin
      err2_q   <= err_d;
      integ2_q <= integ_d;
      filt2_q  <= filt_d;
    end
  end

  assign err_o   = err2_q;
  assign integ_o = integ2_q;
  assign filt_o  = filt2_q;

  a_zero_gain_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i.loop && (cfg_i.integ_gain == '0) |=> integ_q == '0)
    else $error("integral kept a value while its gain is zero");

  a_clear_zeroes_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i.loop && mode_i |=> (filt_q == '0) && (integ_q == '0) && (err2_q == '0))
    else $error("clear transaction left filter or integral state");

endmodule

FILE: rtl/trpi_drive_calc.sv
// PI sum, rounded division by SCALE through a reciprocal multiply with one
// correction step, inversion and saturation into the result register.
// Depends on trpi_pkg.
module trpi_drive_calc #(
  parameter int SCALE = 100
) (
  input  logic                                 clk_i,
  input  trpi_pkg::cfg_t                       cfg_i,
  input  trpi_pkg::pipe_ld_t                   ld_i,
  input  logic signed [trpi_pkg::ERR_W-1:0]    err_i,
  input  logic signed [trpi_pkg::INTEG_W-1:0]  integ_i,
  input  logic signed [trpi_pkg::RATE_W-1:0]   filt_i,
  output logic signed [trpi_pkg::DRIVE_W-1:0]  drive_o,
  output logic signed [trpi_pkg::RATE_W-1:0]   filt_o
);

  localparam int MAG_W   = trpi_pkg::MAG_W;
  localparam int GS_W    = trpi_pkg::GAIN_W + 1;
  localparam int PP_W    = GS_W + trpi_pkg::ERR_W;
  localparam int IP_W    = GS_W + trpi_pkg::INTEG_W;
  localparam int RAW_W   = IP_W + 1;
  localparam int RECIP_W = MAG_W + 1;
  localparam int RECIP   = (2 ** MAG_W) / SCALE;
  localparam int HALF    = SCALE / 2;
  localparam int SCALE_W = $clog2(SCALE + 1);
  localparam int QP_W    = MAG_W + RECIP_W;
  localparam int QS_W    = MAG_W + SCALE_W;

  logic signed [PP_W-1:0]               pp;
  logic signed [IP_W-1:0]               ip;
  logic signed [RAW_W-1:0]              raw;
  logic [RAW_W-1:0]                     raw_mag;
  logic [MAG_W-1:0]                     num_d;

  logic                                 neg3_q;
  logic [MAG_W-1:0]                     num3_q;
  logic signed [trpi_pkg::RATE_W-1:0]   filt3_q;

  logic [QP_W-1:0]                      qprod;
  logic                                 neg4_q;
  logic [MAG_W-1:0]                     num4_q;
  logic [MAG_W-1:0]                     quo4_q;
  logic signed [trpi_pkg::RATE_W-1:0]   filt4_q;

  logic [QS_W-1:0]                      qs;
  logic [MAG_W-1:0]                     rem;
  logic [MAG_W-1:0]                     quo;
  logic [MAG_W-1:0]                     quo_sat;
  logic [trpi_pkg::DRIVE_W-1:0]         drv_mag;
  logic signed [trpi_pkg::DRIVE_W-1:0]  drive_d;

  logic signed [trpi_pkg::DRIVE_W-1:0]  drive5_q;
  logic signed [trpi_pkg::RATE_W-1:0]   filt5_q;

  assign pp      = $signed({1'b0, cfg_i.prop_gain}) * err_i;
  assign ip      = $signed({1'b0, cfg_i.integ_gain}) * integ_i;
  assign raw     = {{(RAW_W - PP_W){pp[PP_W-1]}}, pp} + {ip[IP_W-1], ip};
  assign raw_mag = raw[RAW_W-1] ? RAW_W'(-raw) : RAW_W'(raw);
  assign num_d   = MAG_W'(raw_mag) + MAG_W'(HALF);

  assign qprod   = QP_W'(num3_q) * QP_W'(RECIP);

  assign qs      = QS_W'(quo4_q) * QS_W'(SCALE);
  assign rem     = num4_q - MAG_W'(qs);
  assign quo     = (rem >= MAG_W'(SCALE)) ? quo4_q + MAG_W'(1) : quo4_q;
  assign quo_sat = (quo > MAG_W'(cfg_i.max_drive)) ? MAG_W'(cfg_i.max_drive) : quo;
  assign drv_mag = trpi_pkg::DRIVE_W'(quo_sat);
  assign drive_d = neg4_q ? $signed(-drv_mag) : $signed(drv_mag);

  always_ff @(posedge clk_i) begin
    if (ld_i.mult) begin
      neg3_q  <= raw[RAW_W-1] ^ cfg_i.invert_drive;
      num3_q  <= num_d;
      filt3_q <= filt_i;
    end
    if (ld_i.recip) begin
      neg4_q  <= neg3_q;
      num4_q  <= num3_q;
      quo4_q  <= qprod[MAG_W +: MAG_W];
      filt4_q <= filt3_q;
    end
    if (ld_i.result) begin
      drive5_q <= drive_d;
      filt5_q  <= filt4_q;
    end
  end

  assign drive_o = drive5_q;
  assign filt_o  = filt5_q;

endmodule

FILE: rtl/turn_rate_pi_controller.sv
// Turn rate PI controller top level: six-stage pipeline, one transaction per cycle while the output is not stalled.
// A transaction passes through the input, conversion, loop, multiply, reciprocal and result registers in order.
// Throughput: one transaction per cycle unless the output stalls; the filter and integral update in one stage.
// Stalls propagate stage by stage, so empty stages keep accepting input.
// Reset clears all pipeline valid bits, the filter and integral state, and loads
// the register defaults. Depends on trpi_pkg and the trpi_* modules.
module turn_rate_pi_controller #(
  parameter int SCALE          = 100,
  parameter int FULL_SCALE_DPS = 2000
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [trpi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [trpi_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 mode_i,
  input  logic signed [trpi_pkg::GYRO_W-1:0]   gyro_raw_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [trpi_pkg::DRIVE_W-1:0]  drive_o,
  output logic signed [trpi_pkg::RATE_W-1:0]   filtered_rate_o
);

  localparam int NS = trpi_pkg::NUM_STAGES;

  trpi_pkg::cfg_t                        cfg;
  trpi_pkg::pipe_ld_t                    ld;
  logic [NS-1:0]                         valid_q;
  logic [NS-1:0]                         valid_d;
  logic [NS-1:0]                         en;
  logic [NS-1:0]                         load;

  logic                                  conv_mode;
  logic signed [trpi_pkg::RATE_W-1:0]    conv_rate;
  logic signed [trpi_pkg::ERR_W-1:0]     loop_err;
  logic signed [trpi_pkg::INTEG_W-1:0]   loop_integ;
  logic signed [trpi_pkg::RATE_W-1:0]    loop_filt;

  always_comb begin
    en[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    load[0]    = en[0] && in_valid_i;
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NS; k++) begin
      load[k]    = en[k] && valid_q[k-1];
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  assign ld.in_reg = load[0];
  assign ld.conv   = load[1];
  assign ld.loop   = load[2];
  assign ld.mult   = load[3];
  assign ld.recip  = load[4];
  assign ld.result = load[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NS-1];

  trpi_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  trpi_rate_conv #(
    .FULL_SCALE_DPS (FULL_SCALE_DPS)
  ) u_rate_conv (
    .clk_i      (clk_i),
    .cfg_i      (cfg),
    .ld_i       (ld),
    .mode_i     (mode_i),
    .gyro_raw_i (gyro_raw_i),
    .mode_o     (conv_mode),
    .rate_o     (conv_rate)
  );

  trpi_loop_update u_loop_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .ld_i    (ld),
    .mode_i  (conv_mode),
    .rate_i  (conv_rate),
    .err_o   (loop_err),
    .integ_o (loop_integ),
    .filt_o  (loop_filt)
  );

  trpi_drive_calc #(
    .SCALE (SCALE)
  ) u_drive_calc (
    .clk_i   (clk_i),
    .cfg_i   (cfg),
    .ld_i    (ld),
    .err_i   (loop_err),
    .integ_i (loop_integ),
    .filt_i  (loop_filt),
    .drive_o (drive_o),
    .filt_o  (filtered_rate_o)
  );

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input stalled while a pipeline stage was empty");

  a_drive_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(drive_o) <= $signed({1'b0, cfg.max_drive}))
                 && ($signed(drive_o) >= -$signed({1'b0, cfg.max_drive})))
    else $error("drive outside the saturation limit");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for turn_rate_pi_controller: random and directed gyro
// transactions, register settings per phase, and an in-bench predictor of the PI loop.
// Depends on trpi_pkg and the controller RTL.
`timescale 1ns / 1ps

module testbench;
  import trpi_pkg::*;

  localparam int DRIVE_SCALE  = 100;
  localparam int GYRO_FS_DPS  = 2000;
  localparam int PIPE_LATENCY = 8;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 2000;

  typedef struct {
    logic                     mode;
    logic signed [GYRO_W-1:0] gyro_raw;
  } gyro_item_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [RATE_W-1:0]  filtered_rate;
  } ctrl_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  cfg_idx_e                  cfg_idx_i = CFG_TARGET_RATE;
  logic [CFG_DATA_W-1:0]     cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic                      mode_i = 1'b0;
  logic signed [GYRO_W-1:0]  gyro_raw_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [DRIVE_W-1:0] drive_o;
  logic signed [RATE_W-1:0]  filtered_rate_o;

  gyro_item_t   gyro_items_q[$];
  ctrl_result_t drive_rate_q[$];

  cfg_t                      cfg_model;
  logic signed [INTEG_W-1:0] rate_filt_m = '0;
  logic signed [INTEG_W-1:0] integ_acc_m = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  turn_rate_pi_controller #(
    .SCALE          (DRIVE_SCALE),
    .FULL_SCALE_DPS (GYRO_FS_DPS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .gyro_raw_i      (gyro_raw_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_o         (drive_o),
    .filtered_rate_o (filtered_rate_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint round_div(input longint num, input longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic ctrl_result_t pi_step(input logic clear,
                                           input logic signed [GYRO_W-1:0] raw);
    longint       gyro, dps, err, sum, drv;
    ctrl_result_t res;
    if (clear) begin
      rate_filt_m = '0;
      integ_acc_m = '0;
      res.drive = '0;
      res.filtered_rate = '0;
      return res;
    end
    gyro = longint'(raw) - longint'($signed(cfg_model.zero_offset));
    dps = round_div(gyro * longint'(GYRO_FS_DPS), longint'(32768));
    dps = clamp(dps, -longint'(RATE_NEG_MAX), longint'(RATE_MAX));
    rate_filt_m = INTEG_W'(longint'(rate_filt_m)
                + ((dps - longint'(rate_filt_m)) >>> cfg_model.smooth_shift));
    err = longint'($signed(cfg_model.target_rate)) - longint'(rate_filt_m);
    if (cfg_model.integ_gain != 0)
      integ_acc_m = INTEG_W'(clamp(longint'(integ_acc_m) + err,
                                   -longint'(cfg_model.integ_limit),
                                   longint'(cfg_model.integ_limit)));
    else
      integ_acc_m = '0;
    sum = longint'(cfg_model.prop_gain) * err
        + longint'(cfg_model.integ_gain) * longint'(integ_acc_m);
    drv = round_div(sum, longint'(DRIVE_SCALE));
    if (cfg_model.invert_drive) drv = -drv;
    drv = clamp(drv, -longint'(cfg_model.max_drive), longint'(cfg_model.max_drive));
    res.drive = drv[DRIVE_W-1:0];
    res.filtered_rate = rate_filt_m[RATE_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : driver_proc
    gyro_item_t next_item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i <= 1'b0;
      gyro_raw_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) drive_rate_q.push_back(pi_step(mode_i, gyro_raw_i));
      if (!in_valid_i || in_ready_o) begin
        if (gyro_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = gyro_items_q.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= next_item.mode;
          gyro_raw_i <= next_item.gyro_raw;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    ctrl_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left <= 0;
      hold_ack <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (drive_rate_q.size() == 0) begin
          $error("unexpected transaction: drive %0d filtered_rate %0d", drive_o,
                 filtered_rate_o);
          mismatches++;
        end else begin
          want = drive_rate_q.pop_front();
          if (drive_o !== want.drive) begin
            $error("drive mismatch: expected %0d, actual %0d", want.drive, drive_o);
            mismatches++;
          end
          if (filtered_rate_o !== want.filtered_rate) begin
            $error("filtered_rate mismatch: expected %0d, actual %0d", want.filtered_rate,
                   filtered_rate_o);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
        out_ready_i <= 1'b0;
        hold_left <= LONG_HOLD;
        hold_ack <= hold_req;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    logic signed [TGT_W-1:0] tgt;
    tgt = data[TGT_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TARGET_RATE: begin
        if (tgt > TARGET_MAX) cfg_model.target_rate = TGT_W'(TARGET_MAX);
        else if (tgt < -TARGET_MAX) cfg_model.target_rate = TGT_W'(-TARGET_MAX);
        else cfg_model.target_rate = tgt;
      end
      CFG_PROP_GAIN:    cfg_model.prop_gain = data[GAIN_W-1:0];
      CFG_INTEG_GAIN:   cfg_model.integ_gain = data[GAIN_W-1:0];
      CFG_INTEG_LIMIT:  cfg_model.integ_limit = data[LIMIT_W-1:0];
      CFG_SMOOTH_SHIFT: cfg_model.smooth_shift = data[SHIFT_W-1:0];
      CFG_MAX_DRIVE:    cfg_model.max_drive = data[LIMIT_W-1:0];
      CFG_ZERO_OFFSET:  cfg_model.zero_offset = data;
      CFG_INVERT_DRIVE: cfg_model.invert_drive = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_magnitude();
    case ($urandom_range(2))
      0: return CFG_DATA_W'($urandom);
      1: return CFG_DATA_W'($urandom_range(5000));
      default: return CFG_DATA_W'($urandom_range(50));
    endcase
  endfunction

  task automatic randomize_regs();
    write_reg(CFG_TARGET_RATE, CFG_DATA_W'($urandom));
    write_reg(CFG_PROP_GAIN, CFG_DATA_W'($urandom));
    write_reg(CFG_INTEG_GAIN, ($urandom_range(3) == 0) ? '0 : CFG_DATA_W'($urandom));
    write_reg(CFG_INTEG_LIMIT, pick_magnitude());
    write_reg(CFG_SMOOTH_SHIFT, CFG_DATA_W'($urandom));
    write_reg(CFG_MAX_DRIVE, pick_magnitude());
    write_reg(CFG_ZERO_OFFSET, $urandom_range(1) ? CFG_DATA_W'($urandom)
                                                 : CFG_DATA_W'(int'($urandom_range(400)) - 200));
    write_reg(CFG_INVERT_DRIVE, CFG_DATA_W'($urandom));
  endtask

  task automatic queue_item(input logic mode, input logic signed [GYRO_W-1:0] raw);
    gyro_item_t it;
    it.mode = mode;
    it.gyro_raw = raw;
    gyro_items_q.push_back(it);
  endtask

  // Most bursts stay around one raw level so the filter settles and the integral reaches its clamp; others are random.
  task automatic queue_random(input int count);
    int                       run;
    int                       sel;
    longint                   base;
    longint                   val;
    logic signed [GYRO_W-1:0] rnd;
    while (count > 0) begin
      sel = $urandom_range(3);
      rnd = GYRO_W'($urandom);
      case (sel)
        0: base = longint'(rnd);
        1: base = longint'($signed(cfg_model.zero_offset))
                + longint'($urandom_range(6000)) - longint'(3000);
        default: base = $urandom_range(1) ? longint'(32767) : longint'(-32768);
      endcase
      run = $urandom_range(30, 2);
      while (run > 0 && count > 0) begin
        rnd = GYRO_W'($urandom);
        if (sel == 3) begin
          val = longint'(rnd);
        end else begin
          val = clamp(base + longint'($urandom_range(40)) - longint'(20),
                      longint'(-32768), longint'(32767));
        end
        queue_item($urandom_range(39) == 0, val[GYRO_W-1:0]);
        run--;
        count--;
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (gyro_items_q.size() != 0 || in_valid_i || drive_rate_q.size() != 0)
      @(negedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  task automatic set_idling(input int sel);
    case (sel)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  initial begin
    cfg_model.target_rate = '0;
    cfg_model.prop_gain = PROP_GAIN_RST;
    cfg_model.integ_gain = INTEG_GAIN_RST;
    cfg_model.integ_limit = INTEG_LIMIT_RST;
    cfg_model.smooth_shift = SMOOTH_SHIFT_RST;
    cfg_model.max_drive = MAX_DRIVE_RST;
    cfg_model.zero_offset = '0;
    cfg_model.invert_drive = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: full-scale samples, exact half-way rounding and clears.
    queue_item(1'b1, 16'sh5A5A);
    queue_item(1'b0, 16'sd32767);
    queue_item(1'b0, 16'sd32767);
    queue_item(1'b0, -16'sd32768);
    queue_item(1'b0, -16'sd32768);
    queue_item(1'b0, 16'sd0);
    queue_item(1'b0, 16'sd1024);
    queue_item(1'b0, -16'sd1024);
    queue_item(1'b0, 16'sd1);
    queue_item(1'b0, -16'sd1);
    queue_item(1'b1, -16'sd1);
    queue_item(1'b0, 16'sd16384);
    drain();

    // Every register at its top value but the zero offset, which is at its most negative; the target write saturates.
    write_reg(CFG_TARGET_RATE, 16'hFEC8);
    write_reg(CFG_PROP_GAIN, 16'hFFFF);
    write_reg(CFG_INTEG_GAIN, 16'hFFFF);
    write_reg(CFG_INTEG_LIMIT, 16'hFFFF);
    write_reg(CFG_SMOOTH_SHIFT, 16'hFFFF);
    write_reg(CFG_MAX_DRIVE, 16'hFFFF);
    write_reg(CFG_ZERO_OFFSET, 16'h8000);
    write_reg(CFG_INVERT_DRIVE, 16'hFFFF);
    queue_item(1'b0, 16'sd32767);
    queue_item(1'b0, 16'sd32767);
    queue_item(1'b0, 16'sd32767);
    queue_item(1'b0, -16'sd32768);
    queue_item(1'b0, 16'sd0);
    queue_item(1'b1, 16'sd32767);
    queue_item(1'b0, -16'sd1);
    queue_item(1'b0, 16'sd12345);
    drain();

    // Every register at its bottom value but the zero offset, which is at its most positive; integral gain zero.
    write_reg(CFG_TARGET_RATE, 16'h0100);
    write_reg(CFG_PROP_GAIN, 16'h0000);
    write_reg(CFG_INTEG_GAIN, 16'h0000);
    write_reg(CFG_INTEG_LIMIT, 16'h0000);
    write_reg(CFG_SMOOTH_SHIFT, 16'h0000);
    write_reg(CFG_MAX_DRIVE, 16'h0000);
    write_reg(CFG_ZERO_OFFSET, 16'h7FFF);
    write_reg(CFG_INVERT_DRIVE, 16'h0000);
    queue_item(1'b0, -16'sd32768);
    queue_item(1'b0, 16'sd32767);
    queue_item(1'b0, 16'sd0);
    queue_item(1'b1, 16'sd0);
    queue_item(1'b0, -16'sd1);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      randomize_regs();
      set_idling(phase % 4);
      if (phase == 2) hold_req++;
      queue_random(165);
      drain();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
